@@ hdl/xor_checked_command_frame_handler_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the command frame handler
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKED_COMMAND_FRAME_HANDLER_MACROS_SVH
`define XOR_CHECKED_COMMAND_FRAME_HANDLER_MACROS_SVH

// Same-cycle implication
`define XCFH_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("xcfh assertion failed");

// Next-cycle implication
`define XCFH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("xcfh assertion failed");

`endif

@@ hdl/xcfh_pkg.sv @@
// ----------------------------------------------------------------------------
// xcfh_pkg
// Types and constants shared by the command frame handler modules.
// ----------------------------------------------------------------------------
package xcfh_pkg;

	localparam int FRAME_LEN = 4;
	localparam int Q_DEPTH   = 2;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);

	localparam logic [7:0] OP_SET   = 8'hAA;
	localparam logic [7:0] OP_RESET = 8'h52;
	localparam logic [7:0] RESET_B1 = 8'h45;
	localparam logic [7:0] RESET_B2 = 8'h53;

	localparam logic [0:3][7:0] NOK_REPLY = {8'h4E, 8'h4F, 8'h4B, 8'h4A};

	localparam logic [7:0] TIMEOUT_RESET = 8'd20;

	// Register indexes
	localparam logic [1:0] REG_ENABLED = 2'd0;
	localparam logic [1:0] REG_TIMEOUT = 2'd1;

	// Result kinds
	localparam logic [1:0] KIND_REPLY   = 2'd0;
	localparam logic [1:0] KIND_RELAY   = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	typedef enum logic [1:0] {
		CMD_SET,
		CMD_RESET,
		CMD_NOK
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] lo;
		logic [7:0] hi;
	} cmd_t;

endpackage

@@ hdl/xcfh_front.sv @@
// ----------------------------------------------------------------------------
// xcfh_front
// Frame collection, idle timeout and frame decode into queued commands.
// ----------------------------------------------------------------------------
module xcfh_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  logic [1:0]     wr_index,
	input  logic [7:0]     wr_data,
	input  logic           accept,
	input  logic           operation,
	input  logic [7:0]     rx_byte,
	output logic           push,
	output xcfh_pkg::cmd_t push_cmd
);
	import xcfh_pkg::*;

	logic             enabled_q;
	logic [7:0]       timeout_q;
	logic [0:3][7:0]  frame_q;
	logic [2:0]       count_q;
	logic [2:0]       last_seen_q;
	logic [7:0]       idle_q;

	logic             tick;
	logic             full;
	logic [7:0]       chk;
	logic [7:0]       idle_inc;

	assign tick     = accept && operation && enabled_q;
	assign full     = (count_q == 3'(FRAME_LEN));
	assign chk      = frame_q[0] ^ frame_q[1] ^ frame_q[2] ^ frame_q[3];
	assign idle_inc = (idle_q < timeout_q) ? idle_q + 8'd1 : idle_q;

	assign push = tick && full;

	always_comb begin
		push_cmd.lo = frame_q[1];
		push_cmd.hi = frame_q[2];
		if (chk == 8'h00 && frame_q[0] == OP_SET) begin
			push_cmd.op = CMD_SET;
		end else if (chk == 8'h00 && frame_q[0] == OP_RESET &&
			frame_q[1] == RESET_B1 && frame_q[2] == RESET_B2) begin
			push_cmd.op = CMD_RESET;
		end else begin
			push_cmd.op = CMD_NOK;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b1;
			timeout_q <= TIMEOUT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_ENABLED: enabled_q <= wr_data[0];
				REG_TIMEOUT: timeout_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Frame store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
		end else if (accept && !operation && !full) begin
			frame_q[count_q[1:0]] <= rx_byte;
		end
	end

	// Counts and idle tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			last_seen_q <= '0;
			idle_q      <= '0;
		end else if (accept && !operation) begin
			if (!full) begin
				count_q <= count_q + 3'd1;
			end
		end else if (tick) begin
			if (full) begin
				count_q     <= '0;
				last_seen_q <= 3'(FRAME_LEN);
				idle_q      <= '0;
			end else if (count_q != 3'd0) begin
				if (last_seen_q == count_q) begin
					idle_q <= idle_inc;
					// drop the partial frame once the timeout is reached
					if (idle_inc == timeout_q) begin
						count_q     <= '0;
						last_seen_q <= '0;
					end
				end else begin
					last_seen_q <= count_q;
					idle_q      <= '0;
				end
			end
		end
	end

endmodule

@@ hdl/xcfh_fifo.sv @@
// ----------------------------------------------------------------------------
// xcfh_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module xcfh_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  xcfh_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output xcfh_pkg::cmd_t head_cmd
);
	import xcfh_pkg::*;

	cmd_t                 mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_PTR_W:0]     count_q;

	function automatic logic [Q_PTR_W-1:0] ptr_next(input logic [Q_PTR_W-1:0] p);
		return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
	endfunction

	assign full       = (count_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + (Q_PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (Q_PTR_W+1)'(1);
			end
		end
	end

endmodule

@@ hdl/xcfh_back.sv @@
// ----------------------------------------------------------------------------
// xcfh_back
// Expands each queued command into its result sequence, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module xcfh_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  xcfh_pkg::cmd_t head_cmd,
	output logic           pop,
	input  logic           out_stall,
	output logic           out_valid,
	output logic [1:0]     kind,
	output logic [7:0]     reply_byte,
	output logic [15:0]    relay_word,
	output logic           last
);
	import xcfh_pkg::*;

	logic [2:0]  idx_q;
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  reply_q;
	logic [15:0] relay_q;
	logic        last_q;

	logic        slot_free;
	logic        load;
	logic [1:0]  r_kind;
	logic [7:0]  r_byte;
	logic [15:0] r_word;
	logic        r_last;

	assign slot_free = !out_valid_q || !out_stall;
	assign load      = slot_free && head_valid;
	assign pop       = load && r_last;

	always_comb begin
		r_kind = KIND_REPLY;
		r_byte = 8'h00;
		r_word = 16'h0000;
		r_last = 1'b0;
		case (head_cmd.op)
			CMD_SET: begin
				case (idx_q)
					3'd0: begin
						r_kind = KIND_RELAY;
						r_word = {head_cmd.hi, head_cmd.lo};
					end
					3'd1: r_byte = OP_SET;
					3'd2: r_byte = head_cmd.lo;
					3'd3: r_byte = head_cmd.hi;
					default: begin
						r_byte = OP_SET ^ head_cmd.lo ^ head_cmd.hi;
						r_last = 1'b1;
					end
				endcase
			end
			CMD_RESET: begin
				r_kind = KIND_RESTART;
				r_last = 1'b1;
			end
			default: begin
				r_byte = NOK_REPLY[idx_q[1:0]];
				r_last = (idx_q[1:0] == 2'(FRAME_LEN - 1));
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= head_valid;
			if (load) begin
				idx_q <= r_last ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= r_kind;
			reply_q <= r_byte;
			relay_q <= r_word;
			last_q  <= r_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign reply_byte = reply_q;
	assign relay_word = relay_q;
	assign last       = last_q;

endmodule

@@ hdl/xor_checked_command_frame_handler.sv @@
// ----------------------------------------------------------------------------
// xor_checked_command_frame_handler
// Four-byte XOR-checked command frames in, relay loads, restarts and reply
// bytes out.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake           | Payload
//  ---------+---------------------+------------------------------------------
//  input    | in_valid / in_stall | operation, rx_byte
//  output   | out_valid/out_stall | kind, reply_byte, relay_word, last
//  config   | wr_en               | wr_index, wr_data
//
//  An input transaction is accepted when in_valid is high and in_stall low; a
//  tick on a full frame, while enabled, queues one command. The back part emits
//  one result per cycle from the queue head while out_stall allows: five for
//  SET, one for RESET, four for NOK. Each command waits in the queue, and each
//  result is registered in the output register. in_stall rises only while
//  the two-entry queue is full; out_stall holds the output register and then
//  the queue. Reset clears all control state and the frame.
//
module xor_checked_command_frame_handler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [7:0]  wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  reply_byte,
	output logic [15:0] relay_word,
	output logic        last
);
	import xcfh_pkg::*;

	logic accept;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic q_full;
	logic head_valid;
	cmd_t head_cmd;

	// Hold the input side only when the queue has no room
	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	xcfh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.accept    (accept),
		.operation (operation),
		.rx_byte   (rx_byte),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	xcfh_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	xcfh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.kind       (kind),
		.reply_byte (reply_byte),
		.relay_word (relay_word),
		.last       (last)
	);

endmodule

@@ hdl/xcfh_checker.sv @@
// ----------------------------------------------------------------------------
// xcfh_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "xor_checked_command_frame_handler_macros.svh"

module xcfh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  kind,
	input logic [7:0]  reply_byte,
	input logic [15:0] relay_word,
	input logic        last
);
	import xcfh_pkg::*;

	`XCFH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(kind) && $stable(reply_byte) && $stable(relay_word) && $stable(last))
	`XCFH_ASSERT_NOW(a_relay_not_last, out_valid && kind == KIND_RELAY, !last && reply_byte == 8'h00)
	`XCFH_ASSERT_NOW(a_restart_last, out_valid && kind == KIND_RESTART, last && relay_word == 16'h0000)
	`XCFH_ASSERT_NOW(a_reply_no_word, out_valid && kind == KIND_REPLY, relay_word == 16'h0000)

endmodule

bind xor_checked_command_frame_handler xcfh_checker u_xcfh_checker (.*);

@@ test/tb_xor_checked_command_frame_handler.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_xor_checked_command_frame_handler
// Self-checking bench for the command frame handler. A table of directed
// transactions comes first, then well-formed and broken frames with random
// content. A behavioural predictor tracks the frame, the idle timer and the
// registers, and every result is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_xor_checked_command_frame_handler;

	import xcfh_pkg::*;

	// Input operations
	localparam logic OPER_BYTE = 1'b0;
	localparam logic OPER_TICK = 1'b1;

	// Register indexes with no register behind them
	localparam logic [1:0] REG_SPARE_A = 2'd2;
	localparam logic [1:0] REG_SPARE_B = 2'd3;

	// Cycles waited after the last awaited result until the block is surely quiet
	localparam int SETTLE_CYCLES  = 8;
	// Cycles with no transaction on either channel before giving up
	localparam int WATCHDOG_LIMIT = 2000;
	// Effective input transactions per idling phase
	localparam int PHASE_ITEMS    = 100;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  reply_byte;
		logic [15:0] relay_word;
		logic        last;
	} frame_result_t;

	typedef enum logic [1:0] {ROW_BYTE, ROW_TICK, ROW_WRITE} row_act_t;
	typedef enum logic [1:0] {REPLY_PREDICTED, REPLY_NONE, REPLY_NOK, REPLY_RESTART} reply_form_t;

	typedef struct packed {
		row_act_t    act;
		logic [1:0]  idx;
		logic [7:0]  data;
		reply_form_t form;
	} directed_row_t;

	// ------------------------------------------------------------------------
	// Block ports; every input starts at a known value
	// ------------------------------------------------------------------------
	logic        clk;
	logic        arst_n     = 1'b0;
	logic        wr_en      = 1'b0;
	logic [1:0]  wr_index   = 2'd0;
	logic [7:0]  wr_data    = 8'h00;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic        operation  = 1'b0;
	logic [7:0]  rx_byte    = 8'h00;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  reply_byte;
	logic [15:0] relay_word;
	logic        last;

	xor_checked_command_frame_handler u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.reply_byte (reply_byte),
		.relay_word (relay_word),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Predictor state: a private copy of the frame, the idle timer and the
	// registers, advanced once per accepted input transaction
	// ------------------------------------------------------------------------
	logic [7:0]    rx_frame [0:3];
	logic [2:0]    rx_count    = 3'd0;
	logic [2:0]    seen_count  = 3'd0;
	logic [7:0]    quiet_ticks = 8'd0;
	logic          cfg_enabled = 1'b1;
	logic [7:0]    cfg_timeout = TIMEOUT_RESET;

	frame_result_t step_results[$];
	frame_result_t awaited_results[$];

	int send_gap_pct   = 0;
	int recv_stall_pct = 0;
	int live_items     = 0;
	int fail_count     = 0;

	function automatic frame_result_t make_result(logic [1:0] k, logic [7:0] rb,
			logic [15:0] rw, logic fin);
		frame_result_t r;
		r.kind       = k;
		r.reply_byte = rb;
		r.relay_word = rw;
		r.last       = fin;
		return r;
	endfunction

	// Advance the predicted handler by one transaction and leave its results
	// in step_results
	task automatic predict_frame_handler(input logic op, input logic [7:0] b);
		logic [2:0] n;
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] check;
		logic       ok;
		int         i;
		step_results.delete();
		if (op == OPER_BYTE) begin
			// Store while there is room, drop once the frame is full
			if (rx_count < FRAME_LEN) begin
				rx_frame[rx_count[1:0]] = b;
				rx_count = rx_count + 3'd1;
			end
		end else if (cfg_enabled) begin
			n = rx_count;
			if (n == FRAME_LEN) begin
				lo    = rx_frame[1];
				hi    = rx_frame[2];
				check = rx_frame[0] ^ rx_frame[1] ^ rx_frame[2] ^ rx_frame[3];
				ok    = 1'b0;
				if (check == 8'h00 && rx_frame[0] == OP_SET) begin
					// Relay load first, then the echo with its own check byte
					step_results.push_back(make_result(KIND_RELAY, 8'h00, {hi, lo}, 1'b0));
					step_results.push_back(make_result(KIND_REPLY, OP_SET, 16'h0000, 1'b0));
					step_results.push_back(make_result(KIND_REPLY, lo, 16'h0000, 1'b0));
					step_results.push_back(make_result(KIND_REPLY, hi, 16'h0000, 1'b0));
					step_results.push_back(make_result(KIND_REPLY, OP_SET ^ lo ^ hi,
						16'h0000, 1'b1));
					ok = 1'b1;
				end else if (check == 8'h00 && rx_frame[0] == OP_RESET &&
						rx_frame[1] == RESET_B1 && rx_frame[2] == RESET_B2) begin
					step_results.push_back(make_result(KIND_RESTART, 8'h00, 16'h0000, 1'b1));
					ok = 1'b1;
				end
				rx_count   = 3'd0;
				seen_count = 3'd0;
				if (!ok) begin
					for (i = 0; i < FRAME_LEN; i++)
						step_results.push_back(make_result(KIND_REPLY, NOK_REPLY[i],
							16'h0000, i == FRAME_LEN - 1));
				end
			end
			// Idle tracking works on the count seen at the start of the tick
			if (n != 3'd0) begin
				if (seen_count == n) begin
					if (quiet_ticks < cfg_timeout)
						quiet_ticks = quiet_ticks + 8'd1;
					if (quiet_ticks == cfg_timeout) begin
						rx_count   = 3'd0;
						seen_count = 3'd0;
					end
				end else begin
					seen_count  = n;
					quiet_ticks = 8'd0;
				end
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Input side. Each call starts and ends on a falling edge; valid stays
	// high between back-to-back transactions and drops only for a gap.
	// ------------------------------------------------------------------------
	task automatic send_transaction(input logic op, input logic [7:0] b,
			input reply_form_t form);
		logic ignored;
		int   i;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		rx_byte   <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// Accepted at this edge: account for it before any result can appear
		ignored = (op == OPER_BYTE) ? (rx_count == FRAME_LEN) : !cfg_enabled;
		if (!ignored)
			live_items++;
		predict_frame_handler(op, b);
		case (form)
			REPLY_PREDICTED: begin
				foreach (step_results[j])
					awaited_results.push_back(step_results[j]);
			end
			REPLY_NOK: begin
				for (i = 0; i < FRAME_LEN; i++)
					awaited_results.push_back(make_result(KIND_REPLY, NOK_REPLY[i],
						16'h0000, i == FRAME_LEN - 1));
			end
			REPLY_RESTART: begin
				awaited_results.push_back(make_result(KIND_RESTART, 8'h00, 16'h0000, 1'b1));
			end
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Hold the input until every awaited result has arrived, then let the
	// block settle so that nothing is left in flight
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register write, only ever issued with the block idle
	task automatic write_register(input logic [1:0] idx, input logic [7:0] data);
		wait_quiet();
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_ENABLED: cfg_enabled = data[0];
			REG_TIMEOUT: cfg_timeout = data;
			default: ;
		endcase
	endtask

	// Pick a new register setting; mostly short timeouts so that partial
	// frames really expire, with the extremes and the odd disabled spell
	task automatic pick_setting();
		logic [7:0] tmo;
		logic [7:0] en_word;
		case ($urandom_range(7))
			0: tmo = 8'd1;
			1: tmo = 8'd255;
			2: tmo = 8'd0;
			6: tmo = TIMEOUT_RESET;
			7: tmo = 8'($urandom_range(1, 255));
			default: tmo = 8'($urandom_range(1, 4));
		endcase
		en_word    = 8'($urandom_range(255));
		en_word[0] = ($urandom_range(7) != 0);
		write_register(REG_TIMEOUT, tmo);
		write_register(REG_ENABLED, en_word);
		if ($urandom_range(2) == 0)
			write_register($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
				8'($urandom_range(255)));
	endtask

	// One random sequence: mostly well-formed SET and RESET frames with random
	// content, the rest corrupted, unknown, overlong or partial frames
	task automatic send_random_sequence();
		logic [7:0] body [0:3];
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] mid;
		int         pick;
		int         i;
		pick = $urandom_range(99);
		lo   = 8'($urandom_range(255));
		hi   = 8'($urandom_range(255));
		mid  = 8'($urandom_range(255));
		// Realign: finish and flush any frame left over so this one starts at byte 0
		if (pick < 85 && rx_count != 3'd0) begin
			repeat (FRAME_LEN - rx_count)
				send_transaction(OPER_BYTE, 8'($urandom_range(255)), REPLY_PREDICTED);
			send_transaction(OPER_TICK, 8'($urandom_range(255)), REPLY_PREDICTED);
		end
		if (pick >= 85) begin
			// Partial frame followed by a run of ticks to walk the idle timer
			repeat ($urandom_range(1, 3))
				send_transaction(OPER_BYTE, 8'($urandom_range(255)), REPLY_PREDICTED);
			repeat ($urandom_range(1, 6))
				send_transaction(OPER_TICK, 8'($urandom_range(255)), REPLY_PREDICTED);
		end else begin
			if (pick < 35 || (pick >= 55 && pick < 62))
				body = '{OP_SET, lo, hi, OP_SET ^ lo ^ hi};
			else if (pick < 70)
				body = '{OP_RESET, RESET_B1, RESET_B2, OP_RESET ^ RESET_B1 ^ RESET_B2};
			else if (pick < 78)
				body = '{lo, hi, mid, lo ^ hi ^ mid};
			else
				body = '{lo, hi, mid, 8'($urandom_range(255))};
			// Corrupt one bit of an otherwise good frame
			if (pick >= 55 && pick < 70) begin
				i = $urandom_range(3);
				body[i] = body[i] ^ (8'h01 << $urandom_range(7));
			end
			for (i = 0; i < FRAME_LEN; i++)
				send_transaction(OPER_BYTE, body[i], REPLY_PREDICTED);
			// Bytes beyond a full frame are dropped
			if ($urandom_range(99) < 15)
				repeat ($urandom_range(1, 2))
					send_transaction(OPER_BYTE, 8'($urandom_range(255)), REPLY_PREDICTED);
			send_transaction(OPER_TICK, 8'($urandom_range(255)), REPLY_PREDICTED);
			// A stray tick on an empty frame now and then
			if ($urandom_range(99) < 20)
				send_transaction(OPER_TICK, 8'($urandom_range(255)), REPLY_PREDICTED);
		end
	endtask

	// ------------------------------------------------------------------------
	// Output side: random stall, changed on the falling edge
	// ------------------------------------------------------------------------
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// Compare each accepted result with the oldest awaited one
	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				$error("unexpected result: kind %0d reply_byte %02h relay_word %04h last %0d",
					kind, reply_byte, relay_word, last);
				fail_count++;
			end else begin
				want = awaited_results.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					fail_count++;
				end
				if (reply_byte !== want.reply_byte) begin
					$error("reply_byte: expected %02h, got %02h", want.reply_byte, reply_byte);
					fail_count++;
				end
				if (relay_word !== want.relay_word) begin
					$error("relay_word: expected %04h, got %04h", want.relay_word, relay_word);
					fail_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end the run after too long with no transaction on either channel
	int dead_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			dead_cycles = 0;
		else
			dead_cycles++;
		if (dead_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_xor_checked_command_frame_handler failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Directed transactions. Results are typed in where they are obvious:
	// ticks without a full frame give nothing, RESET gives one restart, a bad
	// check byte gives the NOK reply. The SET echo goes through the predictor.
	// ------------------------------------------------------------------------
	directed_row_t directed_rows [0:31] = '{
		'{ROW_WRITE, REG_TIMEOUT, 8'hFF, REPLY_NONE},       // timeout at its maximum
		'{ROW_WRITE, REG_SPARE_B, 8'hFF, REPLY_NONE},       // index with no register
		'{ROW_TICK,  2'd0,        8'h00, REPLY_NONE},       // tick on an empty frame
		'{ROW_BYTE,  2'd0,        OP_SET, REPLY_NONE},
		'{ROW_BYTE,  2'd0,        8'hFF, REPLY_NONE},
		'{ROW_BYTE,  2'd0,        8'hFF, REPLY_NONE},
		'{ROW_BYTE,  2'd0,        8'hAA, REPLY_NONE},
		'{ROW_BYTE,  2'd0,        8'h00, REPLY_NONE},       // frame full: dropped
		'{ROW_TICK,  2'd0,        8'hFF, REPLY_PREDICTED},  // SET with all-ones word
		'{ROW_BYTE,  2'd0,        OP_RESET, REPLY_NONE},
		'{ROW_BYTE,  2'd0,        RESET_B1, REPLY_NONE},
		'{ROW_BYTE,  2'd0,        RESET_B2, REPLY_NONE},
		'{ROW_BYTE,  2'd0,        8'h44, REPLY_NONE},
		'{ROW_WRITE, REG_ENABLED, 8'hFE, REPLY_NONE},       // disable, upper bits set
		'{ROW_TICK,  2'd0,        8'h00, REPLY_NONE},       // disabled: frame kept
		'{ROW_WRITE, REG_ENABLED, 8'h01, REPLY_NONE},
		'{ROW_TICK,  2'd0,        8'h00, REPLY_RESTART},
		'{ROW_WRITE, REG_TIMEOUT, 8'h00, REPLY_NONE},       // zero timeout
		'{ROW_BYTE,  2'd0,        8'h11, REPLY_NONE},
		'{ROW_TICK,  2'd0,        8'h00, REPLY_NONE},
		'{ROW_TICK,  2'd0,        8'h00, REPLY_NONE},       // discarded on first idle tick
		'{ROW_WRITE, REG_TIMEOUT, 8'h03, REPLY_NONE},
		'{ROW_BYTE,  2'd0,        8'h22, REPLY_NONE},
		'{ROW_TICK,  2'd0,        8'h00, REPLY_NONE},
		'{ROW_TICK,  2'd0,        8'h00, REPLY_NONE},
		'{ROW_TICK,  2'd0,        8'h00, REPLY_NONE},
		'{ROW_WRITE, REG_TIMEOUT, 8'h01, REPLY_NONE},       // lowered below the idle count
		'{ROW_TICK,  2'd0,        8'h00, REPLY_NONE},       // partial frame survives
		'{ROW_BYTE,  2'd0,        8'h33, REPLY_NONE},
		'{ROW_BYTE,  2'd0,        8'h44, REPLY_NONE},
		'{ROW_BYTE,  2'd0,        8'h56, REPLY_NONE},
		'{ROW_TICK,  2'd0,        8'h00, REPLY_NOK}         // check byte wrong
	};

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int phase;
		int phase_start;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_gap_pct   = 25;
		recv_stall_pct = 81;
		foreach (directed_rows[r]) begin
			case (directed_rows[r].act)
				ROW_WRITE: write_register(directed_rows[r].idx, directed_rows[r].data);
				ROW_BYTE:  send_transaction(OPER_BYTE, directed_rows[r].data,
					directed_rows[r].form);
				default:   send_transaction(OPER_TICK, 8'($urandom_range(255)),
					directed_rows[r].form);
			endcase
		end

		// Three idling phases: slow receiver, slow sender, then full rate
		for (phase = 0; phase < 3; phase++) begin
			wait_quiet();
			case (phase)
				0: begin
					send_gap_pct   = 25;
					recv_stall_pct = 81;
				end
				1: begin
					send_gap_pct   = 81;
					recv_stall_pct = 25;
				end
				default: begin
					send_gap_pct   = 0;
					recv_stall_pct = 0;
				end
			endcase
			phase_start = live_items;
			while (live_items - phase_start < PHASE_ITEMS) begin
				pick_setting();
				repeat (cfg_enabled ? 6 : 2)
					send_random_sequence();
			end
		end

		// Drain every awaited result and let the block settle
		wait_quiet();
		if (fail_count == 0)
			$display("tb_xor_checked_command_frame_handler passed");
		else
			$display("tb_xor_checked_command_frame_handler failed");
		$finish;
	end

endmodule
